// ===== hdl/atan2ra_pkg.sv =====
// ----------------------------------------------------------------------------
// atan2ra_pkg
// Shared widths, rational-polynomial coefficients and octant flags for the
// fixed-point atan2 core.
// ----------------------------------------------------------------------------
package atan2ra_pkg;

  localparam int COORD_W_DEF    = 16;
  localparam int ANGLE_FRAC_DEF = 13;
  localparam int ANGLE_W        = 16;  // result port width
  localparam int RATIO_W        = 16;  // Q0.16 ratio min/max
  localparam int NUM_W          = 31;  // numerator after Horner steps
  localparam int PDEN_W         = 31;  // denominator, Q1.30

  // Coefficients, Q2.30
  localparam logic [8:0]  K1 = 9'd338;
  localparam logic [29:0] K2 = 30'd1073713441;
  localparam logic [27:0] K3 = 28'd158312570;
  localparam logic [28:0] K4 = 29'd332840025;
  localparam logic [25:0] K5 = 26'd54011108;
  localparam logic [27:0] K6 = 28'd157951624;
  localparam logic [29:0] K7 = 30'd691988024;
  localparam logic [PDEN_W-1:0] Q30_ONE = 31'd1073741824;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef struct packed {
    logic yneg;  // y below zero: negate
    logic xneg;  // x below zero: reflect through pi
    logic ygtx;  // |y| > |x|: reflect through pi/2
  } oct_flags_t;

  // pi with frac fraction bits, rounded from Q30
  function automatic logic [63:0] pi_scaled(input int frac);
    logic [63:0] rnd;
    rnd = 64'd1 << (29 - frac);
    return (PI_Q30 + rnd) >> (30 - frac);
  endfunction

  function automatic logic [63:0] half_pi_scaled(input int frac);
    logic [63:0] rnd;
    rnd = 64'd1 << (30 - frac);
    return (PI_Q30 + rnd) >> (31 - frac);
  endfunction

endpackage

// ===== hdl/atan2ra_div_pipe.sv =====
// ----------------------------------------------------------------------------
// atan2ra_div_pipe
// Pipelined restoring divider: one quotient bit per stage, Q_W stages.
// Gives floor(rem * 2^Q_W / den) for rem < den, with sideband carried along.
// ----------------------------------------------------------------------------
module atan2ra_div_pipe #(
  parameter int DEN_W = 16,
  parameter int Q_W   = 16,
  parameter int SB_W  = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [DEN_W-1:0] in_rem,
  input  logic [DEN_W-1:0] in_den,
  input  logic [SB_W-1:0]  in_sb,
  output logic             out_valid,
  output logic [Q_W-1:0]   out_quo,
  output logic [SB_W-1:0]  out_sb
);

  logic             vld_r [Q_W];
  logic [DEN_W-1:0] rem_r [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];
  logic [Q_W-1:0]   quo_r [Q_W];
  logic [SB_W-1:0]  sb_r  [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic             src_vld;
    logic [DEN_W-1:0] src_rem;
    logic [DEN_W-1:0] src_den;
    logic [Q_W-1:0]   src_quo;
    logic [SB_W-1:0]  src_sb;
    logic [DEN_W:0]   shl;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] rem_nxt;
    logic [Q_W-1:0]   quo_nxt;

    if (k == 0) begin : g_first
      assign src_vld = in_valid;
      assign src_rem = in_rem;
      assign src_den = in_den;
      assign src_quo = '0;
      assign src_sb  = in_sb;
    end else begin : g_next
      assign src_vld = vld_r[k-1];
      assign src_rem = rem_r[k-1];
      assign src_den = den_r[k-1];
      assign src_quo = quo_r[k-1];
      assign src_sb  = sb_r[k-1];
    end

    assign shl     = {src_rem, 1'b0};
    assign diff    = shl - {1'b0, src_den};
    assign ge      = (shl >= {1'b0, src_den});
    assign rem_nxt = ge ? diff[DEN_W-1:0] : shl[DEN_W-1:0];
    assign quo_nxt = {src_quo[Q_W-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        den_r[k] <= src_den;
        quo_r[k] <= quo_nxt;
        sb_r[k]  <= src_sb;
      end
    end
  end

  assign out_valid = vld_r[Q_W-1];
  assign out_quo   = quo_r[Q_W-1];
  assign out_sb    = sb_r[Q_W-1];

endmodule

// ===== hdl/atan2ra_poly.sv =====
// ----------------------------------------------------------------------------
// atan2ra_poly
// Five-stage evaluation of the rational approximation's numerator (Horner,
// degree 4) and denominator (degree 2) on the Q0.16 ratio.
// ----------------------------------------------------------------------------
module atan2ra_poly (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [atan2ra_pkg::RATIO_W-1:0]      in_ratio,
  input  atan2ra_pkg::oct_flags_t              in_flags,
  output logic                                 out_valid,
  output logic [atan2ra_pkg::NUM_W-1:0]        out_num,
  output logic [atan2ra_pkg::PDEN_W-1:0]       out_den,
  output atan2ra_pkg::oct_flags_t              out_flags
);

  localparam int RW = atan2ra_pkg::RATIO_W;

  // stage 1
  logic                        v1_r;
  logic [RW-1:0]               r1_r;
  atan2ra_pkg::oct_flags_t     f1_r;
  logic [41:0]                 p5_r, p5_nxt;
  logic [45:0]                 p7_r, p7_nxt;
  // stage 2
  logic                        v2_r;
  logic [RW-1:0]               r2_r;
  atan2ra_pkg::oct_flags_t     f2_r;
  logic [28:0]                 t0;
  logic [29:0]                 d0;
  logic [44:0]                 pt0_r, pt0_nxt;
  logic [45:0]                 pd_r, pd_nxt;
  // stage 3
  logic                        v3_r;
  logic [RW-1:0]               r3_r;
  atan2ra_pkg::oct_flags_t     f3_r;
  logic [28:0]                 t1;
  logic [44:0]                 pt1_r, pt1_nxt;
  logic [30:0]                 d3_r, d3_nxt;
  // stage 4
  logic                        v4_r;
  atan2ra_pkg::oct_flags_t     f4_r;
  logic [30:0]                 t2;
  logic [46:0]                 pt2_r, pt2_nxt;
  logic [30:0]                 d4_r;
  // stage 5
  logic                        v5_r;
  atan2ra_pkg::oct_flags_t     f5_r;
  logic [30:0]                 t3_r, t3_nxt;
  logic [30:0]                 d5_r;

  always_comb begin
    p5_nxt  = atan2ra_pkg::K5 * in_ratio;
    p7_nxt  = atan2ra_pkg::K7 * in_ratio;

    t0      = atan2ra_pkg::K4 - p5_r[41:16];
    pt0_nxt = t0 * r1_r;
    d0      = p7_r[45:16] + atan2ra_pkg::K6;
    pd_nxt  = d0 * r1_r;

    t1      = pt0_r[44:16] + atan2ra_pkg::K3;
    pt1_nxt = t1 * r2_r;
    d3_nxt  = pd_r[45:16] + atan2ra_pkg::Q30_ONE;

    t2      = pt1_r[44:16] + atan2ra_pkg::K2;
    pt2_nxt = t2 * r3_r;

    t3_nxt  = pt2_r[46:16] + atan2ra_pkg::K1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_r  <= in_ratio;
      f1_r  <= in_flags;
      p5_r  <= p5_nxt;
      p7_r  <= p7_nxt;
      r2_r  <= r1_r;
      f2_r  <= f1_r;
      pt0_r <= pt0_nxt;
      pd_r  <= pd_nxt;
      r3_r  <= r2_r;
      f3_r  <= f2_r;
      pt1_r <= pt1_nxt;
      d3_r  <= d3_nxt;
      f4_r  <= f3_r;
      pt2_r <= pt2_nxt;
      d4_r  <= d3_r;
      f5_r  <= f4_r;
      t3_r  <= t3_nxt;
      d5_r  <= d4_r;
    end
  end

  assign out_valid = v5_r;
  assign out_num   = t3_r;
  assign out_den   = d5_r;
  assign out_flags = f5_r;

endmodule

// ===== hdl/atan2_rational_approx_core.sv =====
// ----------------------------------------------------------------------------
// atan2_rational_approx_core
// Four-quadrant atan2(y, x) in signed fixed point, saturated to +-pi.
// ----------------------------------------------------------------------------
// Takes one (y, x) request per clock while in_stall is low and returns the
// angle in radians with ANGLE_FRAC_BITS fraction bits (Q3.13 by default), one
// result per request, in order. The pipeline is one magnitude/compare stage,
// 16 stages of the bit-per-stage ratio divider, five multiply stages of the
// rational polynomial, ANGLE_FRAC_BITS + 1 stages of the final rounding
// divider, one reflection stage and the output register. The whole pipeline
// advances together; a two-entry output buffer (output register plus skid)
// decouples it, so in_stall is a registered signal that rises only when both
// entries are held by a stalled consumer.
// ----------------------------------------------------------------------------
module atan2_rational_approx_core #(
  parameter int COORD_WIDTH     = atan2ra_pkg::COORD_W_DEF,
  parameter int ANGLE_FRAC_BITS = atan2ra_pkg::ANGLE_FRAC_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [COORD_WIDTH-1:0]          in_y_coord,
  input  logic signed [COORD_WIDTH-1:0]          in_x_coord,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [atan2ra_pkg::ANGLE_W-1:0] out_angle
);

  localparam int CW    = COORD_WIDTH;
  localparam int FB    = ANGLE_FRAC_BITS;
  localparam int QB_W  = FB + 1;
  localparam int AW    = atan2ra_pkg::ANGLE_W;
  localparam int RES_W = (FB + 4 > AW) ? FB + 4 : AW;
  localparam int FL_W  = $bits(atan2ra_pkg::oct_flags_t);
  localparam int SB1_W = FL_W + 2;

  localparam logic signed [RES_W-1:0] PI_F   = RES_W'(atan2ra_pkg::pi_scaled(FB));
  localparam logic signed [RES_W-1:0] HALF_F = RES_W'(atan2ra_pkg::half_pi_scaled(FB));

  logic pipe_en;

  // ---------------- stage 1: magnitudes and octant ----------------
  logic [CW-1:0]           y_u, x_u, ay, ax, hi, lo;
  atan2ra_pkg::oct_flags_t flags_in;
  logic                    s1_valid_r;
  logic [CW-1:0]           s1_hi_r, s1_lo_r;
  atan2ra_pkg::oct_flags_t s1_flags_r;
  logic                    s1_sat_r, s1_zero_r;

  always_comb begin
    y_u           = in_y_coord;
    x_u           = in_x_coord;
    flags_in.yneg = y_u[CW-1];
    flags_in.xneg = x_u[CW-1];
    ay            = y_u[CW-1] ? (~y_u) + CW'(1) : y_u;
    ax            = x_u[CW-1] ? (~x_u) + CW'(1) : x_u;
    flags_in.ygtx = (ay > ax);
    hi            = flags_in.ygtx ? ay : ax;
    lo            = flags_in.ygtx ? ax : ay;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_hi_r    <= hi;
      s1_lo_r    <= lo;
      s1_flags_r <= flags_in;
      // equal magnitudes would give 1.0, which the ratio cannot hold
      s1_sat_r   <= (lo == hi) && (hi != '0);
      s1_zero_r  <= (hi == '0);
    end
  end

  // ---------------- ratio divider ----------------
  logic                         d1_valid;
  logic [atan2ra_pkg::RATIO_W-1:0] d1_quo, ratio;
  logic [SB1_W-1:0]             d1_sb;
  atan2ra_pkg::oct_flags_t      d1_flags;

  atan2ra_div_pipe #(
    .DEN_W (CW),
    .Q_W   (atan2ra_pkg::RATIO_W),
    .SB_W  (SB1_W)
  ) u_ratio_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (s1_valid_r),
    .in_rem    (s1_lo_r),
    .in_den    (s1_hi_r),
    .in_sb     ({s1_flags_r, s1_sat_r, s1_zero_r}),
    .out_valid (d1_valid),
    .out_quo   (d1_quo),
    .out_sb    (d1_sb)
  );

  assign d1_flags = atan2ra_pkg::oct_flags_t'(d1_sb[SB1_W-1:2]);
  assign ratio    = d1_sb[0] ? '0 : (d1_sb[1] ? '1 : d1_quo);

  // ---------------- polynomial ----------------
  logic                             pl_valid;
  logic [atan2ra_pkg::NUM_W-1:0]    pl_num;
  logic [atan2ra_pkg::PDEN_W-1:0]   pl_den;
  atan2ra_pkg::oct_flags_t          pl_flags;

  atan2ra_poly u_poly (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (d1_valid),
    .in_ratio  (ratio),
    .in_flags  (d1_flags),
    .out_valid (pl_valid),
    .out_num   (pl_num),
    .out_den   (pl_den),
    .out_flags (pl_flags)
  );

  // ---------------- rounding divider: floor(num * 2^(FB+1) / den) ----------------
  logic                    d2_valid;
  logic [QB_W-1:0]         d2_quo;
  logic [FL_W-1:0]         d2_sb;
  atan2ra_pkg::oct_flags_t d2_flags;

  atan2ra_div_pipe #(
    .DEN_W (atan2ra_pkg::PDEN_W),
    .Q_W   (QB_W),
    .SB_W  (FL_W)
  ) u_angle_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (pl_valid),
    .in_rem    (pl_num),
    .in_den    (pl_den),
    .in_sb     (pl_flags),
    .out_valid (d2_valid),
    .out_quo   (d2_quo),
    .out_sb    (d2_sb)
  );

  assign d2_flags = atan2ra_pkg::oct_flags_t'(d2_sb);

  // ---------------- reflection through pi/2 and pi ----------------
  logic [QB_W:0]             q_inc;
  logic signed [RES_W-1:0]   base, ref_a, refl_nxt;
  logic                      refl_valid_r, refl_yneg_r;
  logic signed [RES_W-1:0]   refl_r;

  always_comb begin
    q_inc    = {1'b0, d2_quo} + (QB_W + 1)'(1);
    // half-bit quotient rounds to nearest
    base     = {{(RES_W - QB_W){1'b0}}, q_inc[QB_W:1]};
    ref_a    = d2_flags.ygtx ? HALF_F - base : base;
    refl_nxt = d2_flags.xneg ? PI_F - ref_a : ref_a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refl_valid_r <= 1'b0;
    end else if (pipe_en) begin
      refl_valid_r <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      refl_r      <= refl_nxt;
      refl_yneg_r <= d2_flags.yneg;
    end
  end

  // ---------------- sign, clamp, output buffer ----------------
  logic signed [RES_W-1:0] signed_res, clamp_res;
  logic [AW-1:0]           res_angle;
  logic                    out_valid_r, out_valid_nxt;
  logic [AW-1:0]           out_angle_r, out_angle_nxt;
  logic                    skid_valid_r, skid_valid_nxt;
  logic [AW-1:0]           skid_angle_r, skid_angle_nxt;
  logic                    out_take;

  always_comb begin
    signed_res = refl_yneg_r ? -refl_r : refl_r;
    if (signed_res > PI_F) begin
      clamp_res = PI_F;
    end else if (signed_res < -PI_F) begin
      clamp_res = -PI_F;
    end else begin
      clamp_res = signed_res;
    end
    res_angle = clamp_res[AW-1:0];
  end

  assign out_take = out_valid_r && !out_stall;
  assign pipe_en  = !skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_angle_nxt  = out_angle_r;
    skid_valid_nxt = skid_valid_r;
    skid_angle_nxt = skid_angle_r;
    if (skid_valid_r) begin
      if (out_take) begin
        out_angle_nxt  = skid_angle_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (refl_valid_r) begin
      if (!out_valid_r || out_take) begin
        out_valid_nxt = 1'b1;
        out_angle_nxt = res_angle;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_angle_nxt = res_angle;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_angle_r  <= out_angle_nxt;
    skid_angle_r <= skid_angle_nxt;
  end

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_angle = out_angle_r;

  // ---------------- assertions ----------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with empty output register");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_stall |=> out_valid_r && !skid_valid_r)
    else $error("skid entry not moved to output after take");

  a_request_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> s1_valid_r)
    else $error("accepted request missing from first stage");

  a_zero_ratio: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_zero_r |-> s1_lo_r == '0 && !s1_sat_r)
    else $error("zero-vector flags inconsistent");

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fixed-point atan2 core.
// ----------------------------------------------------------------------------
// Requests (y, x) are queued by the stimulus process and driven one per cycle
// unless stalled, with random sender gaps; the receiver stalls at random and
// once holds off long enough to back the pipeline up. Every accepted request
// is run through a bit-exact predictor; angles are checked against it in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW   = atan2ra_pkg::COORD_W_DEF;
  localparam int FRAC = atan2ra_pkg::ANGLE_FRAC_DEF;
  localparam int AW   = atan2ra_pkg::ANGLE_W;

  // Rational approximation coefficients, Q2.30
  localparam longint A_C1  = 338;
  localparam longint A_C2  = 1073713441;
  localparam longint A_C3  = 158312570;
  localparam longint A_C4  = 332840025;
  localparam longint A_C5  = 54011108;
  localparam longint B_C6  = 157951624;
  localparam longint B_C7  = 691988024;
  localparam longint ONE_Q30 = 64'd1073741824;
  localparam longint PI_Q30_VAL = 64'd3373259426;

  localparam int RAND_PER_PHASE = 225;

  typedef struct packed {
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] x;
  } coord_req_t;

  typedef struct packed {
    coord_req_t                  req;
    logic signed [AW-1:0]        angle;
  } angle_exp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] in_y_coord = '0;
  logic signed [CW-1:0] in_x_coord = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [AW-1:0] out_angle;

  coord_req_t coord_q[$];
  angle_exp_t angle_exp_q[$];

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  logic stall_hold = 1'b0;
  int mismatches = 0;

  always #4 clk = ~clk;

  atan2_rational_approx_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_y_coord (in_y_coord),
    .in_x_coord (in_x_coord),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_angle  (out_angle)
  );

  function automatic logic [AW-1:0] atan2_fixed(logic signed [CW-1:0] y,
                                                logic signed [CW-1:0] x);
    longint ay, ax, hi, lo, ratio, num, den, base, pi_f, half_pi_f, ang;
    ay = (y < 0) ? -longint'(y) : longint'(y);
    ax = (x < 0) ? -longint'(x) : longint'(x);
    hi = (ax > ay) ? ax : ay;
    lo = (ax > ay) ? ay : ax;
    ratio = 0;
    if (hi != 0) begin
      ratio = (lo << 16) / hi;
      if (ratio > 65535) ratio = 65535;
    end
    // Horner on positive terms, numerator then denominator
    num = A_C4 - ((A_C5 * ratio) >> 16);
    num = ((num * ratio) >> 16) + A_C3;
    num = ((num * ratio) >> 16) + A_C2;
    num = ((num * ratio) >> 16) + A_C1;
    den = ((((B_C7 * ratio) >> 16) + B_C6) * ratio >> 16) + ONE_Q30;
    base = ((num << FRAC) + (den >> 1)) / den;
    pi_f = (PI_Q30_VAL + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
    half_pi_f = (PI_Q30_VAL + (64'd1 << (30 - FRAC))) >> (31 - FRAC);
    ang = base;
    if (ay > ax) ang = half_pi_f - ang;
    if (x < 0) ang = pi_f - ang;
    if (y < 0) ang = -ang;
    if (ang > pi_f) ang = pi_f;
    if (ang < -pi_f) ang = -pi_f;
    return ang[AW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    int pick;
    int v;
    pick = $urandom_range(9);
    case (pick)
      0, 1, 2, 3: v = int'($urandom);
      4, 5:       v = int'($urandom_range(16)) - 8;
      6:          v = int'($urandom_range(1023)) - 512;
      7:          v = (1 << $urandom_range(CW - 2)) * (($urandom_range(1) != 0) ? 1 : -1);
      default: begin
        case ($urandom_range(5))
          0: v = -32768;
          1: v = -32767;
          2: v = 32767;
          3: v = 0;
          4: v = -1;
          default: v = 1;
        endcase
      end
    endcase
    return CW'(v);
  endfunction

  function automatic coord_req_t rand_req();
    coord_req_t req;
    int mag, near_mag;
    case ($urandom_range(7))
      0, 1, 2, 3: begin
        req.y = rand_coord();
        req.x = rand_coord();
      end
      4, 5: begin
        // close to the octant diagonal
        mag = int'($urandom_range(32760, 1));
        near_mag = mag + int'($urandom_range(6)) - 3;
        if (near_mag < 0) near_mag = 0;
        req.y = CW'(($urandom_range(1) != 0) ? mag : -mag);
        req.x = CW'(($urandom_range(1) != 0) ? near_mag : -near_mag);
        if ($urandom_range(1)) req = '{y: req.x, x: req.y};
      end
      default: begin
        // one axis zero
        req.y = rand_coord();
        req.x = '0;
        if ($urandom_range(1)) req = '{y: req.x, x: req.y};
      end
    endcase
    return req;
  endfunction

  // Request driver
  always @(posedge clk) begin : req_driver
    coord_req_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_y_coord <= '0;
      in_x_coord <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        angle_exp_q.push_back('{req: '{y: in_y_coord, x: in_x_coord},
                                angle: atan2_fixed(in_y_coord, in_x_coord)});
      end
      if (!in_valid || !in_stall) begin
        if (coord_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          req = coord_q.pop_front();
          in_y_coord <= req.y;
          in_x_coord <= req.x;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall
  always @(posedge clk) begin : angle_monitor
    angle_exp_t exp_item;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (angle_exp_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result angle=%0d", $time, out_angle);
        end else begin
          exp_item = angle_exp_q.pop_front();
          if (out_angle !== exp_item.angle) begin
            mismatches++;
            $display("%0t: y=%0d x=%0d angle expected %0d actual %0d", $time,
                     exp_item.req.y, exp_item.req.x, exp_item.angle, out_angle);
          end
        end
      end
      out_stall <= stall_hold || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Long receiver hold-off early in the unthrottled phase
  initial begin
    wait (rst_n === 1'b1);
    repeat (40) @(posedge clk);
    stall_hold <= 1'b1;
    repeat (300) @(posedge clk);
    stall_hold <= 1'b0;
  end

  initial begin : stimulus
    coord_req_t dir_reqs[$];
    int phase_sender[4];
    int phase_recv[4];
    int ph, idx;
    phase_sender = '{0, 46, 0, 18};
    phase_recv   = '{0, 0, 46, 18};
    dir_reqs = '{
      '{y: 16'sd0, x: 16'sd0}, '{y: 16'sd0, x: 16'sd1}, '{y: 16'sd0, x: -16'sd1},
      '{y: 16'sd1, x: 16'sd0}, '{y: -16'sd1, x: 16'sd0}, '{y: 16'sd0, x: -16'sd32768},
      '{y: -16'sd32768, x: 16'sd0}, '{y: -16'sd32768, x: -16'sd32768},
      '{y: 16'sd32767, x: 16'sd32767}, '{y: 16'sd32767, x: -16'sd32768},
      '{y: -16'sd32768, x: 16'sd32767}, '{y: 16'sd5, x: 16'sd5},
      '{y: 16'sd5, x: -16'sd5}, '{y: -16'sd5, x: 16'sd5}, '{y: -16'sd5, x: -16'sd5},
      '{y: 16'sd32767, x: 16'sd0}, '{y: 16'sd0, x: 16'sd32767},
      '{y: 16'sd100, x: 16'sd99}, '{y: 16'sd99, x: 16'sd100},
      '{y: 16'sd1, x: 16'sd32767}, '{y: 16'sd32767, x: 16'sd1},
      '{y: -16'sd1, x: -16'sd32768}, '{y: 16'sd12345, x: -16'sd23456}
    };
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_reqs[i]) coord_q.push_back(dir_reqs[i]);
    for (ph = 0; ph < 4; ph++) begin
      @(posedge clk);
      sender_idle_pct <= phase_sender[ph];
      recv_stall_pct <= phase_recv[ph];
      for (idx = 0; idx < RAND_PER_PHASE; idx++) coord_q.push_back(rand_req());
      while (coord_q.size() != 0) @(posedge clk);
    end
    while (coord_q.size() != 0 || in_valid || angle_exp_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && !out_valid) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/atan2ra_pkg.sv
hdl/atan2ra_div_pipe.sv
hdl/atan2ra_poly.sv
hdl/atan2_rational_approx_core.sv
verif/tb_top.sv
